### sv/tgr_pkg.sv
`default_nettype none
package tgr_pkg;

  localparam int PosW   = 12;
  localparam int MoveW  = 13;
  localparam int GestW  = 3;
  localparam int ActW   = 2;
  localparam int CfgAW  = 2;
  localparam int CfgDW  = 16;
  localparam int InDW   = 32;
  localparam int OutDW  = 56;

  localparam int CoordBitsDef = 12;
  localparam int TimeBitsDef  = 16;

  localparam logic [11:0] SwipeMinLenRst = 12'd50;
  localparam logic [15:0] SwipeMaxTimeRst = 16'd500;
  localparam logic [15:0] LpIntervalRst   = 16'd1000;
  localparam logic [11:0] MoveThreshRst   = 12'd10;

  typedef enum logic [ActW-1:0] {
    ACT_PRESS   = 2'd0,
    ACT_MOVE    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_TICK    = 2'd3
  } action_e;

  typedef enum logic [GestW-1:0] {
    GEST_TAP         = 3'd0,
    GEST_SWIPE_LEFT  = 3'd1,
    GEST_SWIPE_RIGHT = 3'd2,
    GEST_SWIPE_UP    = 3'd3,
    GEST_SWIPE_DOWN  = 3'd4,
    GEST_LP_START    = 3'd5,
    GEST_LP_END      = 3'd6,
    GEST_MOVE_FWD    = 3'd7
  } gesture_e;

  typedef enum logic [CfgAW-1:0] {
    REG_SWIPE_MIN_LEN  = 2'd0,
    REG_SWIPE_MAX_TIME = 2'd1,
    REG_LP_INTERVAL    = 2'd2,
    REG_MOVE_THRESH    = 2'd3
  } cfg_reg_e;

endpackage
`default_nettype wire

### sv/touch_gesture_recognizer_unit.sv
// A result appears on the master side in the cycle after its input transaction is accepted.
// Throughput: one input transaction per cycle while input is not stalled; state is updated in the accepting cycle.
// The output register holds a waiting result, so the next input is not taken while it waits:
// input stalls only while that register is full and the master side is not ready.
// Reset (rst_ni low, asynchronous): state and counters clear, registers take defaults.
`default_nettype none
module touch_gesture_recognizer_unit #(
  parameter int COORD_BITS = tgr_pkg::CoordBitsDef,
  parameter int TIME_BITS  = tgr_pkg::TimeBitsDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire  [tgr_pkg::CfgAW-1:0]  cfg_addr_i,
  input  wire  [tgr_pkg::CfgDW-1:0]  cfg_wdata_i,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // pos_x, pos_y, long_press_allowed
  input  wire  [tgr_pkg::InDW-1:0]   s_axis_tdata,
  // action
  input  wire  [tgr_pkg::ActW-1:0]   s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // point_x, point_y, move_dx, move_dy
  output logic [tgr_pkg::OutDW-1:0]  m_axis_tdata,
  // gesture
  output logic [tgr_pkg::GestW-1:0]  m_axis_tuser
);

  localparam int PW = tgr_pkg::PosW;
  localparam int DW = tgr_pkg::MoveW;
  localparam int CW = COORD_BITS;
  localparam int TW = TIME_BITS;

  logic [11:0] swipe_min_q;
  logic [15:0] swipe_max_q;
  logic [15:0] lp_interval_q;
  logic [11:0] move_thresh_q;

  logic [CW-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [CW-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic          running_q, running_d, holding_q, holding_d, permitted_q, permitted_d;
  logic [TW-1:0] hold_cnt_q, hold_cnt_d, age_q, age_d;

  logic                   out_valid_q, out_valid_d;
  tgr_pkg::gesture_e      gest_q, gest_d;
  logic [PW-1:0]          ox_q, ox_d, oy_q, oy_d;
  logic signed [DW-1:0]   odx_q, odx_d, ody_q, ody_d;

  tgr_pkg::action_e act;
  logic [CW-1:0]    px, py;
  logic             allowed;
  logic             in_acc;

  logic signed [CW:0] mv_dx, mv_dy, rel_dx, rel_dy;
  logic [CW-1:0]      mv_ax, mv_ay, rel_ax, rel_ay, rel_m;
  logic [CW:0]        mv_sum;
  logic [TW-1:0]      age_inc, hc_inc;
  logic               res_valid;
  tgr_pkg::gesture_e  res_g;
  logic [CW-1:0]      res_x, res_y;
  logic signed [CW:0] res_dx, res_dy;

  assign act     = tgr_pkg::action_e'(s_axis_tuser);
  assign px      = CW'(s_axis_tdata[PW-1:0]);
  assign py      = CW'(s_axis_tdata[2*PW-1:PW]);
  assign allowed = s_axis_tdata[2*PW];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign mv_dx  = $signed({1'b0, px}) - $signed({1'b0, last_x_q});
  assign mv_dy  = $signed({1'b0, py}) - $signed({1'b0, last_y_q});
  assign rel_dx = $signed({1'b0, px}) - $signed({1'b0, start_x_q});
  assign rel_dy = $signed({1'b0, py}) - $signed({1'b0, start_y_q});
  assign mv_ax  = mv_dx[CW]  ? CW'(-mv_dx)  : CW'(mv_dx);
  assign mv_ay  = mv_dy[CW]  ? CW'(-mv_dy)  : CW'(mv_dy);
  assign rel_ax = rel_dx[CW] ? CW'(-rel_dx) : CW'(rel_dx);
  assign rel_ay = rel_dy[CW] ? CW'(-rel_dy) : CW'(rel_dy);
  assign mv_sum = {1'b0, mv_ax} + {1'b0, mv_ay};
  assign rel_m  = (rel_ax > rel_ay) ? rel_ax : rel_ay;

  assign age_inc = (age_q == '1) ? age_q : age_q + TW'(1);
  assign hc_inc  = (hold_cnt_q == '1) ? hold_cnt_q : hold_cnt_q + TW'(1);

  always_comb begin
    start_x_d   = start_x_q;
    start_y_d   = start_y_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    running_d   = running_q;
    holding_d   = holding_q;
    permitted_d = permitted_q;
    hold_cnt_d  = hold_cnt_q;
    age_d       = age_q;
    res_valid   = 1'b0;
    res_g       = tgr_pkg::GEST_TAP;
    res_x       = last_x_q;
    res_y       = last_y_q;
    res_dx      = '0;
    res_dy      = '0;
    case (act)
      tgr_pkg::ACT_PRESS: begin
        start_x_d   = px;
        start_y_d   = py;
        last_x_d    = px;
        last_y_d    = py;
        permitted_d = allowed;
        running_d   = 1'b1;
        hold_cnt_d  = '0;
        age_d       = '0;
      end
      tgr_pkg::ACT_MOVE: begin
        if (running_q) begin
          if (32'(mv_sum) > 32'(move_thresh_q)) begin
            hold_cnt_d = '0;
            last_x_d   = px;
            last_y_d   = py;
          end
        end else if (holding_q) begin
          res_valid = 1'b1;
          res_g     = tgr_pkg::GEST_MOVE_FWD;
          res_x     = px;
          res_y     = py;
        end
      end
      tgr_pkg::ACT_RELEASE: begin
        last_x_d = px;
        last_y_d = py;
        if (running_q) begin
          running_d = 1'b0;
          res_x     = start_x_q;
          res_y     = start_y_q;
          if (32'(rel_m) < 32'(swipe_min_q)) begin
            res_valid = 1'b1;
            res_g     = tgr_pkg::GEST_TAP;
          end else if (!(32'(age_q) > 32'(swipe_max_q))) begin
            res_valid = 1'b1;
            res_dx    = rel_dx;
            res_dy    = rel_dy;
            if (rel_ax > rel_ay) begin
              res_g = rel_dx[CW] ? tgr_pkg::GEST_SWIPE_LEFT : tgr_pkg::GEST_SWIPE_RIGHT;
            end else begin
              res_g = rel_dy[CW] ? tgr_pkg::GEST_SWIPE_UP : tgr_pkg::GEST_SWIPE_DOWN;
            end
          end
        end else if (holding_q) begin
          holding_d = 1'b0;
          res_valid = 1'b1;
          res_g     = tgr_pkg::GEST_LP_END;
          res_x     = px;
          res_y     = py;
        end
      end
      tgr_pkg::ACT_TICK: begin
        age_d = age_inc;
        if (running_q) begin
          hold_cnt_d = hc_inc;
          if (32'(hc_inc) >= 32'(lp_interval_q)) begin
            if (!permitted_q) begin
              hold_cnt_d = '0;
            end else begin
              running_d = 1'b0;
              holding_d = 1'b1;
              res_valid = 1'b1;
              res_g     = tgr_pkg::GEST_LP_START;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    gest_d      = gest_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    odx_d       = odx_q;
    ody_d       = ody_q;
    if (in_acc && res_valid) begin
      out_valid_d = 1'b1;
      gest_d      = res_g;
      ox_d        = PW'(res_x);
      oy_d        = PW'(res_y);
      odx_d       = DW'(res_dx);
      ody_d       = DW'(res_dy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swipe_min_q   <= tgr_pkg::SwipeMinLenRst;
      swipe_max_q   <= tgr_pkg::SwipeMaxTimeRst;
      lp_interval_q <= tgr_pkg::LpIntervalRst;
      move_thresh_q <= tgr_pkg::MoveThreshRst;
      start_x_q     <= '0;
      start_y_q     <= '0;
      last_x_q      <= '0;
      last_y_q      <= '0;
      running_q     <= 1'b0;
      holding_q     <= 1'b0;
      permitted_q   <= 1'b1;
      hold_cnt_q    <= '0;
      age_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (tgr_pkg::cfg_reg_e'(cfg_addr_i))
          tgr_pkg::REG_SWIPE_MIN_LEN:  swipe_min_q   <= cfg_wdata_i[11:0];
          tgr_pkg::REG_SWIPE_MAX_TIME: swipe_max_q   <= cfg_wdata_i;
          tgr_pkg::REG_LP_INTERVAL:    lp_interval_q <= cfg_wdata_i;
          tgr_pkg::REG_MOVE_THRESH:    move_thresh_q <= cfg_wdata_i[11:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        start_x_q   <= start_x_d;
        start_y_q   <= start_y_d;
        last_x_q    <= last_x_d;
        last_y_q    <= last_y_d;
        running_q   <= running_d;
        holding_q   <= holding_d;
        permitted_q <= permitted_d;
        hold_cnt_q  <= hold_cnt_d;
        age_q       <= age_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gest_q <= gest_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    odx_q  <= odx_d;
    ody_q  <= ody_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = gest_q;
  assign m_axis_tdata  = {(tgr_pkg::OutDW - 2*PW - 2*DW)'(0), ody_q, odx_q, oy_q, ox_q};

endmodule
`default_nettype wire

### sv/tgr_checker.sv
`default_nettype none
module tgr_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       s_axis_tvalid,
  input wire                       s_axis_tready,
  input wire                       m_axis_tvalid,
  input wire                       m_axis_tready,
  input wire [tgr_pkg::OutDW-1:0]  m_axis_tdata,
  input wire [tgr_pkg::GestW-1:0]  m_axis_tuser
);

  logic non_swipe;
  assign non_swipe = (m_axis_tuser == tgr_pkg::GEST_TAP) ||
                     (m_axis_tuser == tgr_pkg::GEST_LP_START) ||
                     (m_axis_tuser == tgr_pkg::GEST_LP_END) ||
                     (m_axis_tuser == tgr_pkg::GEST_MOVE_FWD);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input taken while result stalled");

  a_zero_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && non_swipe |-> m_axis_tdata[49:24] == 26'd0)
    else $error("movement nonzero for non-swipe transaction");

  a_swipe_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tgr_pkg::GEST_SWIPE_LEFT ||
                      m_axis_tuser == tgr_pkg::GEST_SWIPE_RIGHT) |->
      m_axis_tdata[36] == (m_axis_tuser == tgr_pkg::GEST_SWIPE_LEFT))
    else $error("horizontal swipe direction disagrees with dx sign");

endmodule

bind touch_gesture_recognizer_unit tgr_checker u_tgr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import tgr_pkg::*;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgAW-1:0]     cfg_addr_i    = '0;
  logic [CfgDW-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // pos_x, pos_y, long_press_allowed
  logic [InDW-1:0]      s_axis_tdata  = '0;
  // action
  logic [ActW-1:0]      s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // point_x, point_y, move_dx, move_dy
  logic [OutDW-1:0]     m_axis_tdata;
  // gesture
  logic [GestW-1:0]     m_axis_tuser;

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  int sent_items   = 0;

  touch_gesture_recognizer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  typedef struct {
    gesture_e    gest;
    logic [11:0] px;
    logic [11:0] py;
    logic [12:0] dx;
    logic [12:0] dy;
  } gesture_t;

  class gesture_scoreboard;
    gesture_t    gestures_q[$];
    int          failures;
    logic [11:0] min_len, thresh;
    logic [15:0] max_time, interval;
    logic [11:0] start_x, start_y, last_x, last_y;
    bit          timer_on, holding, hold_ok;
    logic [15:0] hold_cnt, age;

    function new();
      failures = 0;
      min_len  = SwipeMinLenRst;
      max_time = SwipeMaxTimeRst;
      interval = LpIntervalRst;
      thresh   = MoveThreshRst;
      start_x  = '0;
      start_y  = '0;
      last_x   = '0;
      last_y   = '0;
      timer_on = 1'b0;
      holding  = 1'b0;
      hold_ok  = 1'b1;
      hold_cnt = '0;
      age      = '0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] v);
      case (idx)
        REG_SWIPE_MIN_LEN:  min_len  = v[11:0];
        REG_SWIPE_MAX_TIME: max_time = v;
        REG_LP_INTERVAL:    interval = v;
        REG_MOVE_THRESH:    thresh   = v[11:0];
        default: ;
      endcase
    endfunction

    function void push(gesture_e g, logic [11:0] x, logic [11:0] y, int dx, int dy);
      gesture_t e;
      e.gest = g;
      e.px   = x;
      e.py   = y;
      e.dx   = 13'(dx);
      e.dy   = 13'(dy);
      gestures_q.push_back(e);
    endfunction

    function void note_input(action_e act, logic [11:0] px, logic [11:0] py, bit allowed);
      int dx, dy, ax, ay, m;
      gesture_e g;
      case (act)
        ACT_PRESS: begin
          start_x  = px;
          start_y  = py;
          last_x   = px;
          last_y   = py;
          hold_ok  = allowed;
          timer_on = 1'b1;
          hold_cnt = '0;
          age      = '0;
        end
        ACT_MOVE: begin
          if (timer_on) begin
            dx = int'(px) - int'(last_x);
            dy = int'(py) - int'(last_y);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (ax + ay > int'(thresh)) begin
              hold_cnt = '0;
              last_x   = px;
              last_y   = py;
            end
          end else if (holding) begin
            push(GEST_MOVE_FWD, px, py, 0, 0);
          end
        end
        ACT_RELEASE: begin
          last_x = px;
          last_y = py;
          if (timer_on) begin
            dx = int'(last_x) - int'(start_x);
            dy = int'(last_y) - int'(start_y);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            m  = (ax > ay) ? ax : ay;
            timer_on = 1'b0;
            if (m < int'(min_len)) begin
              push(GEST_TAP, start_x, start_y, 0, 0);
            end else if (age <= max_time) begin
              if (ax > ay) g = (dx < 0) ? GEST_SWIPE_LEFT : GEST_SWIPE_RIGHT;
              else         g = (dy < 0) ? GEST_SWIPE_UP : GEST_SWIPE_DOWN;
              push(g, start_x, start_y, dx, dy);
            end
          end else if (holding) begin
            holding = 1'b0;
            push(GEST_LP_END, last_x, last_y, 0, 0);
          end
        end
        default: begin
          if (age != 16'hFFFF) age = age + 16'd1;
          if (timer_on) begin
            if (hold_cnt != 16'hFFFF) hold_cnt = hold_cnt + 16'd1;
            if (hold_cnt >= interval) begin
              if (!hold_ok) begin
                hold_cnt = '0;
              end else begin
                timer_on = 1'b0;
                holding  = 1'b1;
                push(GEST_LP_START, last_x, last_y, 0, 0);
              end
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic [GestW-1:0] g, logic [OutDW-1:0] d);
      gesture_t e;
      if (gestures_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected gesture %0d point (%0d,%0d)", g, d[11:0], d[23:12]);
        return;
      end
      e = gestures_q.pop_front();
      if (g !== e.gest || d[11:0] !== e.px || d[23:12] !== e.py ||
          d[36:24] !== e.dx || d[49:37] !== e.dy) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: gesture exp %0d got %0d, point exp (%0d,%0d) got (%0d,%0d), %s",
                   e.gest, g, e.px, e.py, d[11:0], d[23:12],
                   $sformatf("move exp (%0d,%0d) got (%0d,%0d)", $signed(e.dx),
                             $signed(e.dy), $signed(d[36:24]), $signed(d[49:37])));
      end
    endfunction

    function void final_check();
      if (gestures_q.size() != 0) begin
        failures += gestures_q.size();
        $display("%0d expected gestures never arrived", gestures_q.size());
      end
    endfunction
  endclass

  gesture_scoreboard sb;

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i)
    m_axis_tready <= !sink_idle_en || ($urandom_range(99) >= 27);

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);

  function automatic logic [11:0] nudge(logic [11:0] p, int span);
    int v;
    v = int'(p) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  task automatic send_item(action_e act, logic [11:0] px, logic [11:0] py, bit allowed);
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      if (src_idle_en && $urandom_range(99) < 27) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, allowed, py, px};
        s_axis_tuser  <= act;
        do @(posedge clk_i); while (!s_axis_tready);
        sb.note_input(act, px, py, allowed);
        sent_items++;
        done = 1'b1;
      end
    end
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.gestures_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_config(int min_len, int max_time, int interval, int thresh);
    wait_drain();
    write_reg(REG_SWIPE_MIN_LEN, 16'(min_len));
    write_reg(REG_SWIPE_MAX_TIME, 16'(max_time));
    write_reg(REG_LP_INTERVAL, 16'(interval));
    write_reg(REG_MOVE_THRESH, 16'(thresh));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_gesture();
    logic [11:0] cx, cy;
    int kind, span;
    if ($urandom_range(99) < 10) begin
      send_item(action_e'($urandom_range(3)), 12'($urandom), 12'($urandom), 1'($urandom));
      return;
    end
    cx = 12'($urandom);
    cy = 12'($urandom);
    send_item(ACT_PRESS, cx, cy, $urandom_range(99) < 75);
    repeat ($urandom_range(14)) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        repeat ($urandom_range(1, 8))
          send_item(ACT_TICK, 12'($urandom), 12'($urandom), 1'($urandom));
      end else begin
        span = (kind < 80) ? 15 : (kind < 92) ? 80 : 4095;
        cx = nudge(cx, span);
        cy = nudge(cy, span);
        send_item(ACT_MOVE, cx, cy, 1'($urandom));
      end
    end
    kind = $urandom_range(99);
    span = (kind < 40) ? 20 : (kind < 80) ? 200 : 4095;
    send_item(ACT_RELEASE, nudge(cx, span), nudge(cy, span), 1'($urandom));
    if ($urandom_range(99) < 20)
      send_item(ACT_MOVE, 12'($urandom), 12'($urandom), 1'($urandom));
  endtask

  task automatic run_phase(int target, int min_len, int max_time, int interval, int thresh);
    int first;
    apply_config(min_len, max_time, interval, thresh);
    first = sent_items;
    while (sent_items - first < target) begin
      run_gesture();
      if ($urandom_range(99) < 4) wait_drain();
    end
  endtask

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: 60 px is a swipe, 40 px a tap
    send_item(ACT_PRESS, 12'd500, 12'd500, 1'b1);
    send_item(ACT_RELEASE, 12'd560, 12'd500, 1'b0);
    send_item(ACT_PRESS, 12'd500, 12'd500, 1'b1);
    send_item(ACT_RELEASE, 12'd540, 12'd500, 1'b0);

    apply_config(50, 3, 2, 10);
    send_item(ACT_RELEASE, 12'd7, 12'd7, 1'b0);
    send_item(ACT_MOVE, 12'd9, 12'd9, 1'b0);
    send_item(ACT_PRESS, 12'd100, 12'd200, 1'b1);
    send_item(ACT_RELEASE, 12'd100, 12'd200, 1'b0);
    send_item(ACT_PRESS, 12'd2000, 12'd2000, 1'b1);
    send_item(ACT_RELEASE, 12'd1900, 12'd2010, 1'b0);
    send_item(ACT_PRESS, 12'd2000, 12'd2000, 1'b1);
    send_item(ACT_RELEASE, 12'd2100, 12'd2000, 1'b0);
    send_item(ACT_PRESS, 12'd2000, 12'd2000, 1'b1);
    send_item(ACT_RELEASE, 12'd2000, 12'd1940, 1'b0);
    send_item(ACT_PRESS, 12'd2000, 12'd2000, 1'b1);
    send_item(ACT_RELEASE, 12'd2060, 12'd2060, 1'b0);
    // long press forbidden: timer restarts, then a slow swipe is dropped
    send_item(ACT_PRESS, 12'd0, 12'd0, 1'b0);
    repeat (5) send_item(ACT_TICK, 12'd4095, 12'd4095, 1'b1);
    send_item(ACT_RELEASE, 12'd4095, 12'd4095, 1'b1);
    send_item(ACT_PRESS, 12'd4095, 12'd0, 1'b1);
    send_item(ACT_MOVE, 12'd4092, 12'd3, 1'b0);
    send_item(ACT_TICK, 12'd0, 12'd0, 1'b0);
    send_item(ACT_MOVE, 12'd4000, 12'd100, 1'b0);
    send_item(ACT_TICK, 12'd0, 12'd0, 1'b0);
    send_item(ACT_TICK, 12'd0, 12'd0, 1'b0);
    send_item(ACT_MOVE, 12'd3990, 12'd110, 1'b0);
    send_item(ACT_RELEASE, 12'd3980, 12'd120, 1'b0);
    send_item(ACT_PRESS, 12'd4095, 12'd4095, 1'b1);
    send_item(ACT_RELEASE, 12'd0, 12'd0, 1'b0);

    // long press with a forwarded move, then a forbidden one ending in a slow swipe
    apply_config(50, 65535, 20, 10);
    send_item(ACT_PRESS, 12'd1000, 12'd1000, 1'b1);
    repeat (25) send_item(ACT_TICK, 12'd0, 12'd0, 1'b0);
    send_item(ACT_MOVE, 12'd1010, 12'd1000, 1'b0);
    send_item(ACT_RELEASE, 12'd1000, 12'd1000, 1'b0);
    apply_config(50, 10, 20, 10);
    send_item(ACT_PRESS, 12'd10, 12'd10, 1'b0);
    repeat (45) send_item(ACT_TICK, 12'd0, 12'd0, 1'b0);
    send_item(ACT_RELEASE, 12'd3000, 12'd10, 1'b0);
    send_item(ACT_PRESS, 12'd10, 12'd10, 1'b1);
    send_item(ACT_RELEASE, 12'd12, 12'd10, 1'b0);

    run_phase(115, 0, 65535, 1, 0);
    run_phase(115, 4095, 0, 65535, 4095);
    run_phase(115, $urandom_range(100), $urandom_range(60), 0, $urandom_range(4095));
    run_phase(115, $urandom_range(120), $urandom_range(80), $urandom_range(1, 30),
              $urandom_range(40));
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_phase(115, $urandom_range(120), $urandom_range(80), $urandom_range(1, 30),
              $urandom_range(40));
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    run_phase(115, $urandom_range(120), $urandom_range(80), $urandom_range(1, 30),
              $urandom_range(40));

    wait_drain();
    repeat (10) @(posedge clk_i);
    sb.final_check();
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
